// ===== hdl/frame_animation_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Frame animation sequencer assertion macros
// Implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_ANIMATION_SEQUENCER_ASSERT_SVH
`define FRAME_ANIMATION_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

`define FAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame sequencer check failed");

`define FAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame sequencer check failed");

`else

`define FAS_ASSERT_IMP(lbl, ante, cons)

`define FAS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame animation sequencer package
// Request, status and mode codes, field widths and the request/result layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package fas_pkg;

  localparam int MAX_FRAMES  = 16;
  localparam int DW          = 32;
  localparam int FW          = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;

  localparam logic [2:0] REQ_ADVANCE = 3'd0;
  localparam logic [2:0] REQ_RESTART = 3'd1;
  localparam logic [2:0] REQ_PAUSE   = 3'd2;
  localparam logic [2:0] REQ_WRITE   = 3'd3;
  localparam logic [2:0] REQ_START   = 3'd4;
  localparam logic [2:0] REQ_STOP    = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic [1:0] MODE_ONCE = 2'd0;
  localparam logic [1:0] MODE_LOOP = 2'd1;
  localparam logic [1:0] MODE_PP   = 2'd2;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_TOTAL = 1'b1;

  typedef struct packed {
    logic [31:0] slot_duration;
    logic [3:0]  slot;
    logic        pause_flag;
    logic [31:0] step_ms;
  } fas_req_t;

  typedef struct packed {
    logic        reverse;
    logic        paused_now;
    logic        finished;
    logic [31:0] frame_elapsed;
    logic [3:0]  frame_num;
    logic [1:0]  status;
  } fas_result_t;

endpackage

`default_nettype wire

// ===== hdl/fas_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/frame_animation_sequencer.sv =====
// ----------------------------------------------------------------------------
// Frame animation sequencer
// Once, loop and ping-pong frame sequencing over a table of frame durations,
// one shared add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// Start reads and sums every frame duration. Advance runs a bit-serial modulo
// in loop and ping-pong, then walks each frame boundary crossed, and adds to the
// elapsed time when the step ends inside a frame. One request at a time;
// in_tready is low until the result is registered, longer while out_tready is low.
// Synchronous reset stops the sequence; the duration table keeps its contents.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frame_animation_sequencer_assert.svh"

module frame_animation_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // step_ms, pause_flag, slot, slot_duration, zero pad
  input  wire logic [fas_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type
  input  wire logic [2:0]                       in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status, frame_num, frame_elapsed, finished, paused_now, reverse, zero pad
  output logic      [fas_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_addr,
  input  wire logic [4:0]                       cfg_wdata
);

  import fas_pkg::*;

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = DW + $clog2(2 * MAX_FRAMES);
  localparam int AL = CW + 1;
  localparam int RW = $bits(fas_req_t);
  localparam int OW = $bits(fas_result_t);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ST_RD  = 4'd1;
  localparam logic [3:0] S_ST_ACC = 4'd2;
  localparam logic [3:0] S_MOD    = 4'd3;
  localparam logic [3:0] S_WK_RD  = 4'd4;
  localparam logic [3:0] S_WK_REM = 4'd5;
  localparam logic [3:0] S_WK_CMP = 4'd6;
  localparam logic [3:0] S_WK_ADD = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  fas_req_t    req;
  logic        accept;
  logic        slot_ok;
  logic        ram_we;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] rdata;

  logic [3:0]    state_r,     state_nxt;
  logic [FW-1:0] idx_r,       idx_nxt;
  logic [CW-1:0] sum_r,       sum_nxt;
  logic [CW-1:0] cyc_r,       cyc_nxt;
  logic [CW-1:0] rem_r,       rem_nxt;
  logic [DW-1:0] dlt_r,       dlt_nxt;
  logic [4:0]    bit_r,       bit_nxt;
  logic [DW-1:0] remf_r,      remf_nxt;
  logic [DW-1:0] dur_r,       dur_nxt;
  logic [FW-1:0] frame_r,     frame_nxt;
  logic [DW-1:0] el_r,        el_nxt;
  logic          bwd_r,       bwd_nxt;
  logic          pause_r,     pause_nxt;
  logic          done_r,      done_nxt;
  logic          ready_r,     ready_nxt;
  logic [1:0]    run_mode_r,  run_mode_nxt;
  logic [FW-1:0] run_count_r, run_count_nxt;
  logic [1:0]    mode_cfg_r;
  logic [FW-1:0] total_cfg_r;
  logic [1:0]    status_r,    status_nxt;
  logic          out_valid_r, out_valid_nxt;
  fas_result_t   out_res_r,   out_res_nxt;

  logic [AL-1:0] alu_a;
  logic [AL-1:0] alu_b;
  logic          alu_sub;
  logic [AL:0]   alu_res;
  logic          alu_borrow;
  logic          interior;
  logic [CW-1:0] mod_rem;
  logic [FW:0]   frame_inc;
  logic [FW:0]   frame_inc2;
  logic [FW-1:0] frame_dec;

  assign req       = fas_req_t'(in_tdata[RW-1:0]);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_ok   = (32'(req.slot) < 32'(MAX_FRAMES));
  assign ram_we    = accept && (in_tuser == REQ_WRITE) && slot_ok;
  assign ram_raddr = (state_r == S_ST_RD) ? AW'(idx_r) : AW'(frame_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OW)'(0), out_res_r};

  fas_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_FRAMES)
  ) u_dur_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(req.slot)),
    .wdata (req.slot_duration),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // ping-pong interior frames count twice in the cycle length
  assign interior = (mode_cfg_r == MODE_PP) && (idx_r != '0) &&
                    (idx_r != total_cfg_r - FW'(1));

  // shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_ST_ACC: begin
        alu_a = AL'(sum_r);
        alu_b = interior ? AL'({rdata, 1'b0}) : AL'(rdata);
      end
      S_MOD: begin
        alu_a   = {rem_r, dlt_r[DW-1]};
        alu_b   = AL'(cyc_r);
        alu_sub = 1'b1;
      end
      S_WK_REM: begin
        alu_a   = AL'(rdata);
        alu_b   = AL'(el_r);
        alu_sub = 1'b1;
      end
      S_WK_CMP: begin
        alu_a   = AL'(dlt_r);
        alu_b   = AL'(remf_r);
        alu_sub = 1'b1;
      end
      S_WK_ADD: begin
        alu_a = AL'(el_r);
        alu_b = AL'(dlt_r);
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  assign alu_borrow = alu_sub && alu_res[AL];
  assign mod_rem    = alu_borrow ? alu_a[CW-1:0] : alu_res[CW-1:0];
  assign frame_inc  = {1'b0, frame_r} + (FW+1)'(1);
  assign frame_inc2 = {1'b0, frame_r} + (FW+1)'(2);
  assign frame_dec  = (frame_r != '0) ? frame_r - FW'(1) : '0;

  always_comb begin
    logic stop_walk;
    stop_walk     = 1'b0;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    cyc_nxt       = cyc_r;
    rem_nxt       = rem_r;
    dlt_nxt       = dlt_r;
    bit_nxt       = bit_r;
    remf_nxt      = remf_r;
    dur_nxt       = dur_r;
    frame_nxt     = frame_r;
    el_nxt        = el_r;
    bwd_nxt       = bwd_r;
    pause_nxt     = pause_r;
    done_nxt      = done_r;
    ready_nxt     = ready_r;
    run_mode_nxt  = run_mode_r;
    run_count_nxt = run_count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_tuser)
            REQ_ADVANCE: begin
              if (!ready_r) begin
                status_nxt = ST_NOT_READY;
              end else if (!pause_r && !done_r && (req.step_ms != '0)) begin
                dlt_nxt = req.step_ms;
                if (run_mode_r != MODE_ONCE) begin
                  rem_nxt   = '0;
                  bit_nxt   = '0;
                  state_nxt = S_MOD;
                end else begin
                  state_nxt = S_WK_RD;
                end
              end
            end
            REQ_RESTART: begin
              if (!ready_r) begin
                status_nxt = ST_NOT_READY;
              end else begin
                frame_nxt = '0;
                el_nxt    = '0;
                bwd_nxt   = 1'b0;
                pause_nxt = 1'b0;
                done_nxt  = 1'b0;
              end
            end
            REQ_PAUSE: begin
              if (!ready_r) begin
                status_nxt = ST_NOT_READY;
              end else begin
                pause_nxt = req.pause_flag;
              end
            end
            REQ_WRITE: begin
              if (slot_ok) begin
                ready_nxt = 1'b0;
              end else begin
                status_nxt = ST_INVALID;
              end
            end
            REQ_START: begin
              if ((mode_cfg_r != MODE_ONCE && mode_cfg_r != MODE_LOOP &&
                   mode_cfg_r != MODE_PP) || (total_cfg_r == '0) ||
                  (32'(total_cfg_r) > 32'(MAX_FRAMES))) begin
                status_nxt = ST_INVALID;
              end else begin
                idx_nxt   = '0;
                sum_nxt   = '0;
                state_nxt = S_ST_RD;
              end
            end
            REQ_STOP: begin
              cyc_nxt       = '0;
              frame_nxt     = '0;
              el_nxt        = '0;
              bwd_nxt       = 1'b0;
              pause_nxt     = 1'b0;
              done_nxt      = 1'b0;
              ready_nxt     = 1'b0;
              run_mode_nxt  = MODE_ONCE;
              run_count_nxt = '0;
            end
            default: begin
              status_nxt = ST_INVALID;
            end
          endcase
        end
      end
      S_ST_RD: begin
        state_nxt = S_ST_ACC;
      end
      S_ST_ACC: begin
        if (rdata == '0) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_DONE;
        end else if (idx_r == total_cfg_r - FW'(1)) begin
          cyc_nxt       = alu_res[CW-1:0];
          run_mode_nxt  = mode_cfg_r;
          run_count_nxt = total_cfg_r;
          frame_nxt     = '0;
          el_nxt        = '0;
          bwd_nxt       = 1'b0;
          pause_nxt     = 1'b0;
          done_nxt      = 1'b0;
          ready_nxt     = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          sum_nxt   = alu_res[CW-1:0];
          idx_nxt   = idx_r + FW'(1);
          state_nxt = S_ST_RD;
        end
      end
      S_MOD: begin
        // restoring remainder, one delta bit per cycle
        rem_nxt = mod_rem;
        dlt_nxt = {dlt_r[DW-2:0], 1'b0};
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'(DW - 1)) begin
          dlt_nxt   = mod_rem[DW-1:0];
          state_nxt = (mod_rem == '0) ? S_DONE : S_WK_RD;
        end
      end
      S_WK_RD: begin
        state_nxt = S_WK_REM;
      end
      S_WK_REM: begin
        dur_nxt   = rdata;
        remf_nxt  = alu_borrow ? '0 : alu_res[DW-1:0];
        state_nxt = S_WK_CMP;
      end
      S_WK_CMP: begin
        if (alu_borrow) begin
          state_nxt = S_WK_ADD;
        end else begin
          dlt_nxt = alu_res[DW-1:0];
          el_nxt  = '0;
          case (run_mode_r)
            MODE_ONCE: begin
              if (frame_inc < {1'b0, run_count_r}) begin
                frame_nxt = frame_inc[FW-1:0];
              end else begin
                el_nxt    = dur_r;
                done_nxt  = 1'b1;
                stop_walk = 1'b1;
              end
            end
            MODE_LOOP: begin
              frame_nxt = (frame_inc == {1'b0, run_count_r}) ? '0 : frame_inc[FW-1:0];
            end
            default: begin
              if (run_count_r <= FW'(1)) begin
                frame_nxt = '0;
              end else if (!bwd_r) begin
                frame_nxt = frame_inc[FW-1:0];
                if (frame_inc2 == {1'b0, run_count_r}) begin
                  bwd_nxt = 1'b1;
                end
              end else begin
                frame_nxt = frame_dec;
                if (frame_dec == '0) begin
                  bwd_nxt = 1'b0;
                end
              end
            end
          endcase
          state_nxt = (stop_walk || (alu_res[DW-1:0] == '0)) ? S_DONE : S_WK_RD;
        end
      end
      S_WK_ADD: begin
        el_nxt    = alu_res[DW-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt             = 1'b1;
          out_res_nxt.status        = status_r;
          out_res_nxt.frame_num     = frame_r[3:0];
          out_res_nxt.frame_elapsed = el_r;
          out_res_nxt.finished      = done_r;
          out_res_nxt.paused_now    = pause_r;
          out_res_nxt.reverse       = bwd_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cyc_r       <= '0;
      frame_r     <= '0;
      el_r        <= '0;
      bwd_r       <= 1'b0;
      pause_r     <= 1'b0;
      done_r      <= 1'b0;
      ready_r     <= 1'b0;
      run_mode_r  <= MODE_ONCE;
      run_count_r <= '0;
      mode_cfg_r  <= MODE_ONCE;
      total_cfg_r <= FW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cyc_r       <= cyc_nxt;
      frame_r     <= frame_nxt;
      el_r        <= el_nxt;
      bwd_r       <= bwd_nxt;
      pause_r     <= pause_nxt;
      done_r      <= done_nxt;
      ready_r     <= ready_nxt;
      run_mode_r  <= run_mode_nxt;
      run_count_r <= run_count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MODE:  mode_cfg_r  <= cfg_wdata[1:0];
          CFG_TOTAL: total_cfg_r <= cfg_wdata;
          default:   mode_cfg_r  <= mode_cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_nxt_hold: begin
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
      rem_r     <= rem_nxt;
      dlt_r     <= dlt_nxt;
      bit_r     <= bit_nxt;
      remf_r    <= remf_nxt;
      dur_r     <= dur_nxt;
      status_r  <= status_nxt;
      out_res_r <= out_res_nxt;
    end
  end

  `FAS_ASSERT_IMP(a_ready_has_run, ready_r, (run_count_r != '0) && (cyc_r != '0))
  `FAS_ASSERT_IMP(a_frame_in_run, ready_r, frame_r < run_count_r)
  `FAS_ASSERT_IMP(a_done_once_only, done_r, run_mode_r == MODE_ONCE)
  `FAS_ASSERT_IMP(a_bwd_pp_only, bwd_r, run_mode_r == MODE_PP)
  `FAS_ASSERT_NXT(a_mod_nonzero, state_r == S_MOD, (state_r != S_MOD) || (cyc_r != '0))

endmodule

`default_nettype wire
